### hw/rtl/base64_record_line_decoder_assert.svh
// Assertion macros used by the decoder RTL.
`ifndef BASE64_RECORD_LINE_DECODER_ASSERT_SVH
`define BASE64_RECORD_LINE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define B64RL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("b64rl assertion failed");

`define B64RL_ASSERT_NEVER(name, clk, rst, expr) \
   `B64RL_ASSERT(name, clk, rst, !(expr))

`else

`define B64RL_ASSERT(name, clk, rst, prop)

`define B64RL_ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

### hw/rtl/b64rl_pkg.sv
package b64rl_pkg;

   // Line buffer geometry: decoded bytes are kept as 24-bit groups of three.
   localparam int LINE_BUFFER_BYTES = 18;
   localparam int RECORD_BYTES      = 16;
   localparam int GROUP_BYTES       = 3;
   localparam int NUM_GROUPS        = LINE_BUFFER_BYTES / GROUP_BYTES;
   localparam int GROUP_COUNT_W     = $clog2(NUM_GROUPS + 1);
   localparam int GROUP_IDX_W       = $clog2(NUM_GROUPS);
   localparam int RECORD_GROUPS     = (RECORD_BYTES + GROUP_BYTES - 1) / GROUP_BYTES;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_LEFTOVER = 2'd2;
   localparam logic [1:0] STATUS_SHORT    = 2'd3;

   // Character codes.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Sextet values at the start of each alphabet range.
   localparam logic [7:0] SEXTET_LOWER_BASE = 8'd26;
   localparam logic [7:0] SEXTET_DIGIT_BASE = 8'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  year_offset;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic [31:0] power_watts;
      logic [31:0] cost_cents;
      logic [15:0] voltage_raw;
   } rsp_type;

   // Standard base64 alphabet; the pad character decodes as a zero sextet.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] t;
      s = '0;
      t = '0;
      unique case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
            t = c - CHAR_UPPER_A;
            s = '{ok: 1'b1, value: t[5:0]};
         end
         [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
            t = c - CHAR_LOWER_A + SEXTET_LOWER_BASE;
            s = '{ok: 1'b1, value: t[5:0]};
         end
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: begin
            t = c - CHAR_DIGIT_0 + SEXTET_DIGIT_BASE;
            s = '{ok: 1'b1, value: t[5:0]};
         end
         CHAR_PLUS:  s = '{ok: 1'b1, value: SEXTET_PLUS};
         CHAR_SLASH: s = '{ok: 1'b1, value: SEXTET_SLASH};
         CHAR_PAD:   s = '{ok: 1'b1, value: 6'd0};
         default:    s = '{ok: 1'b0, value: 6'd0};
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/b64rl_req_if.sv
interface b64rl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       ends_stream;

   modport source (output valid, output char_code, output ends_stream, input ready);
   modport sink   (input valid, input char_code, input ends_stream, output ready);
endinterface

### hw/rtl/b64rl_rsp_if.sv
interface b64rl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  year_offset;
   logic [7:0]  month;
   logic [7:0]  day;
   logic [7:0]  hour;
   logic [7:0]  minute;
   logic [7:0]  second;
   logic [31:0] power_watts;
   logic [31:0] cost_cents;
   logic [15:0] voltage_raw;

   modport source (output valid, output status, output year_offset, output month,
                   output day, output hour, output minute, output second,
                   output power_watts, output cost_cents, output voltage_raw,
                   input ready);
   modport sink   (input valid, input status, input year_offset, input month,
                   input day, input hour, input minute, input second,
                   input power_watts, input cost_cents, input voltage_raw,
                   output ready);
endinterface

### hw/rtl/base64_record_line_decoder.sv
// Channel  Direction  Payload                                        Handshake
// req_if   in         char_code[7:0], ends_stream                    valid/ready
// rsp_if   out        status, date/time bytes, power, cost, voltage  valid/ready
//
// One character is taken per cycle. It is decoded in the input register, and
// a record it completes is registered in a two-entry queue and offered in order.
// Reset is synchronous and active high; it clears the input register, the line
// state, the abort flag and the result queue, and the block is ready once it ends.
// The input stalls only when a character would produce a record while both
// result queue entries are still waiting to be taken.

`include "base64_record_line_decoder_assert.svh"

module base64_record_line_decoder (
   input logic           clock,
   input logic           reset,
   b64rl_req_if.sink     req_if,
   b64rl_rsp_if.source   rsp_if
);

   // Input register stage.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // Line state. Decoded bytes are held as 24-bit groups, most significant
   // byte first, exactly as they fall out of the sextet accumulator.
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  sextet_cnt_ff, sextet_cnt_in;
   logic [b64rl_pkg::GROUP_COUNT_W-1:0] group_cnt_ff, group_cnt_in;
   logic [23:0] group_ff [b64rl_pkg::NUM_GROUPS];
   logic        aborted_ff, aborted_in;

   // Result queue.
   b64rl_pkg::rsp_type rsp_q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] q_cnt_ff, q_cnt_in;

   b64rl_pkg::sextet_type sx;
   logic        is_newline;
   logic        has_result;
   logic        s1_fire;
   logic        push;
   logic        pop;
   logic        group_write;
   logic [23:0] acc_shift;
   logic [1:0]  cnt_inc;
   logic [1:0]  fin_cnt;
   logic [b64rl_pkg::GROUP_COUNT_W-1:0] fin_groups;
   logic [23:0] fin_group [b64rl_pkg::NUM_GROUPS];
   logic [7:0]  rec [b64rl_pkg::RECORD_BYTES];
   b64rl_pkg::rsp_type result;

   // Decode of the character in the input register.
   always_comb begin
      sx         = b64rl_pkg::sextet_of(s1_char_ff);
      is_newline = (s1_char_ff == b64rl_pkg::CHAR_NEWLINE);
      acc_shift  = {acc_ff[17:0], sx.value};
      cnt_inc    = sextet_cnt_ff + 2'd1;
      // A fourth sextet completes a group; groups past the buffer are dropped.
      group_write = !is_newline && sx.ok && (sextet_cnt_ff == 2'd3) &&
                    (group_cnt_ff < b64rl_pkg::GROUP_COUNT_W'(b64rl_pkg::NUM_GROUPS));
   end

   // A record closes at a newline or at the last character of the stream; an
   // invalid character reports at once. Nothing is reported while aborted.
   assign has_result = !aborted_ff && (is_newline || !sx.ok || s1_last_ff);

   // The queue count is registered, so the stall decision never looks at
   // rsp_if.ready in the same cycle.
   assign s1_fire = s1_valid_ff && (!has_result || (q_cnt_ff != 2'd2));
   assign push    = s1_fire && has_result;
   assign pop     = rsp_if.valid && rsp_if.ready;

   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in  = req_if.ready ? req_if.valid : s1_valid_ff;

   // Line state as seen when the record closes. For a data character this
   // includes the sextet and any group it has just completed.
   always_comb begin
      if (is_newline) begin
         fin_cnt    = sextet_cnt_ff;
         fin_groups = group_cnt_ff;
      end else begin
         fin_cnt    = cnt_inc;
         fin_groups = group_cnt_ff + b64rl_pkg::GROUP_COUNT_W'(1);
         if (!group_write) begin
            fin_groups = group_cnt_ff;
         end
      end
      for (int k = 0; k < b64rl_pkg::NUM_GROUPS; k++) begin
         fin_group[k] = (group_write && (group_cnt_ff == b64rl_pkg::GROUP_COUNT_W'(k)))
                        ? acc_shift : group_ff[k];
      end
   end

   // Record bytes; a byte that was never decoded on this line reads as zero.
   always_comb begin
      for (int i = 0; i < b64rl_pkg::RECORD_BYTES; i++) begin
         rec[i] = (fin_groups > b64rl_pkg::GROUP_COUNT_W'(i / b64rl_pkg::GROUP_BYTES))
                  ? fin_group[i / b64rl_pkg::GROUP_BYTES]
                             [23 - 8 * (i % b64rl_pkg::GROUP_BYTES) -: 8]
                  : 8'd0;
      end
   end

   always_comb begin
      result = '0;
      if (!is_newline && !sx.ok) begin
         result.status = b64rl_pkg::STATUS_INVALID;
      end else if (fin_cnt != 2'd0) begin
         // The line stopped in the middle of a group.
         result.status = b64rl_pkg::STATUS_LEFTOVER;
      end else begin
         result.status = (fin_groups < b64rl_pkg::GROUP_COUNT_W'(b64rl_pkg::RECORD_GROUPS))
                         ? b64rl_pkg::STATUS_SHORT : b64rl_pkg::STATUS_OK;
         result.year_offset = rec[0];
         result.month       = rec[1];
         result.day         = rec[2];
         result.hour        = rec[3];
         result.minute      = rec[4];
         result.second      = rec[5];
         result.power_watts = {rec[9], rec[8], rec[7], rec[6]};
         result.cost_cents  = {rec[13], rec[12], rec[11], rec[10]};
         result.voltage_raw = {rec[15], rec[14]};
      end
   end

   // Next line state.
   always_comb begin
      acc_in        = acc_ff;
      sextet_cnt_in = sextet_cnt_ff;
      group_cnt_in  = group_cnt_ff;
      aborted_in    = aborted_ff;
      if (s1_fire) begin
         if (aborted_ff) begin
            // Characters are dropped until the end of the stream.
            if (s1_last_ff) begin
               aborted_in    = 1'b0;
               acc_in        = '0;
               sextet_cnt_in = '0;
               group_cnt_in  = '0;
            end
         end else if (has_result) begin
            acc_in        = '0;
            sextet_cnt_in = '0;
            group_cnt_in  = '0;
            // Any error aborts the rest of the stream unless the stream ends here.
            if (result.status == b64rl_pkg::STATUS_INVALID ||
                result.status == b64rl_pkg::STATUS_LEFTOVER) begin
               aborted_in = !s1_last_ff;
            end
         end else begin
            acc_in        = acc_shift;
            sextet_cnt_in = cnt_inc;
            group_cnt_in  = fin_groups;
         end
      end
   end

   always_comb begin
      q_cnt_in = q_cnt_ff;
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         acc_ff        <= '0;
         sextet_cnt_ff <= '0;
         group_cnt_ff  <= '0;
         aborted_ff    <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         q_cnt_ff      <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         acc_ff        <= acc_in;
         sextet_cnt_ff <= sextet_cnt_in;
         group_cnt_ff  <= group_cnt_in;
         aborted_ff    <= aborted_in;
         q_cnt_ff      <= q_cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_char_ff <= req_if.char_code;
         s1_last_ff <= req_if.ends_stream;
      end
      if (s1_fire && !aborted_ff && !has_result && group_write) begin
         group_ff[group_cnt_ff[b64rl_pkg::GROUP_IDX_W-1:0]] <= acc_shift;
      end
      if (push) begin
         rsp_q_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_if.valid       = (q_cnt_ff != 2'd0);
   assign rsp_if.status      = rsp_q_ff[rd_ptr_ff].status;
   assign rsp_if.year_offset = rsp_q_ff[rd_ptr_ff].year_offset;
   assign rsp_if.month       = rsp_q_ff[rd_ptr_ff].month;
   assign rsp_if.day         = rsp_q_ff[rd_ptr_ff].day;
   assign rsp_if.hour        = rsp_q_ff[rd_ptr_ff].hour;
   assign rsp_if.minute      = rsp_q_ff[rd_ptr_ff].minute;
   assign rsp_if.second      = rsp_q_ff[rd_ptr_ff].second;
   assign rsp_if.power_watts = rsp_q_ff[rd_ptr_ff].power_watts;
   assign rsp_if.cost_cents  = rsp_q_ff[rd_ptr_ff].cost_cents;
   assign rsp_if.voltage_raw = rsp_q_ff[rd_ptr_ff].voltage_raw;

   // The result queue never holds more than its two entries.
   `B64RL_ASSERT_NEVER(a_queue_bound, clock, reset, q_cnt_ff == 2'd3)

   // The group count never runs past the line buffer.
   `B64RL_ASSERT_NEVER(a_group_bound, clock, reset,
                       group_cnt_ff > b64rl_pkg::GROUP_COUNT_W'(b64rl_pkg::NUM_GROUPS))

   // An invalid character in mid-stream puts the block into the abort state.
   `B64RL_ASSERT(a_abort_on_invalid, clock, reset,
                 (s1_fire && !aborted_ff && !is_newline && !sx.ok && !s1_last_ff)
                 |=> aborted_ff)

   // While aborted no record is queued.
   `B64RL_ASSERT_NEVER(a_no_push_aborted, clock, reset, push && aborted_ff)

endmodule

### tb/base64_record_line_decoder_tb.sv
`timescale 1ns / 1ps

module base64_record_line_decoder_tb;

   // The run is ended by force if it has not finished after this many cycles.
   localparam int unsigned CYCLE_LIMIT = 500000;

   // Least number of characters accepted by the block per idling phase.
   localparam int unsigned PHASE_ITEMS = 235;

   // Cycles that are allowed to pass after the last record before the run is
   // closed. A record reaches the output through the input register and the result queue.
   localparam int unsigned TAIL_CYCLES = 8;

   // Keeps a cycle-free copy of the decoder state and the records that the
   // block still owes. Each accepted character updates the copy, and each
   // record that leaves the block is compared with the oldest one owed.
   class record_scoreboard;
      b64rl_pkg::rsp_type expected_records[$];
      logic [23:0] bit_buffer = '0;
      logic [1:0]  sextets_held = '0;
      logic [7:0]  line_buf[b64rl_pkg::LINE_BUFFER_BYTES];
      int unsigned bytes_held = 0;
      bit          dropping = 1'b0;
      int unsigned errors = 0;
      int unsigned checked = 0;

      // Maps one character to its sextet; the pad character counts as zero.
      static function bit decode_sextet(input logic [7:0] c, output logic [5:0] v);
         v = '0;
         if (c >= b64rl_pkg::CHAR_UPPER_A && c <= b64rl_pkg::CHAR_UPPER_Z)
            v = 6'(c - b64rl_pkg::CHAR_UPPER_A);
         else if (c >= b64rl_pkg::CHAR_LOWER_A && c <= b64rl_pkg::CHAR_LOWER_Z)
            v = 6'(c - b64rl_pkg::CHAR_LOWER_A + b64rl_pkg::SEXTET_LOWER_BASE);
         else if (c >= b64rl_pkg::CHAR_DIGIT_0 && c <= b64rl_pkg::CHAR_DIGIT_9)
            v = 6'(c - b64rl_pkg::CHAR_DIGIT_0 + b64rl_pkg::SEXTET_DIGIT_BASE);
         else if (c == b64rl_pkg::CHAR_PLUS)
            v = b64rl_pkg::SEXTET_PLUS;
         else if (c == b64rl_pkg::CHAR_SLASH)
            v = b64rl_pkg::SEXTET_SLASH;
         else if (c != b64rl_pkg::CHAR_PAD)
            return 1'b0;
         return 1'b1;
      endfunction

      function void clear_line();
         bit_buffer   = '0;
         sextets_held = '0;
         bytes_held   = 0;
      endfunction

      // Bytes past the decoded count read as zero, so a short line pads out.
      function logic [7:0] record_byte(int unsigned i);
         return (i < bytes_held) ? line_buf[i] : 8'h00;
      endfunction

      function void push_error(logic [1:0] code);
         b64rl_pkg::rsp_type r;
         r = '0;
         r.status = code;
         expected_records.push_back(r);
      endfunction

      function void close_line(bit last);
         b64rl_pkg::rsp_type r;
         if (sextets_held != 0) begin
            push_error(b64rl_pkg::STATUS_LEFTOVER);
            if (!last) dropping = 1'b1;
            clear_line();
            return;
         end
         r.status      = (bytes_held < b64rl_pkg::RECORD_BYTES) ?
                         b64rl_pkg::STATUS_SHORT : b64rl_pkg::STATUS_OK;
         r.year_offset = record_byte(0);
         r.month       = record_byte(1);
         r.day         = record_byte(2);
         r.hour        = record_byte(3);
         r.minute      = record_byte(4);
         r.second      = record_byte(5);
         r.power_watts = {record_byte(9), record_byte(8), record_byte(7), record_byte(6)};
         r.cost_cents  = {record_byte(13), record_byte(12), record_byte(11), record_byte(10)};
         r.voltage_raw = {record_byte(15), record_byte(14)};
         expected_records.push_back(r);
         clear_line();
      endfunction

      // Notes one accepted character; while waiting for the end of the stream
      // after an error, the character is dropped.
      function void note_char(logic [7:0] c, bit last);
         logic [5:0] v;
         if (dropping) begin
            if (last) begin
               dropping = 1'b0;
               clear_line();
            end
            return;
         end
         if (c == b64rl_pkg::CHAR_NEWLINE) begin
            close_line(last);
            return;
         end
         if (!decode_sextet(c, v)) begin
            push_error(b64rl_pkg::STATUS_INVALID);
            clear_line();
            if (!last) dropping = 1'b1;
            return;
         end
         bit_buffer   = {bit_buffer[17:0], v};
         sextets_held = sextets_held + 2'd1;
         if (sextets_held == 0) begin
            for (int k = 0; k < b64rl_pkg::GROUP_BYTES; k++) begin
               if (bytes_held < b64rl_pkg::LINE_BUFFER_BYTES) begin
                  line_buf[bytes_held] = bit_buffer[23 - 8 * k -: 8];
                  bytes_held++;
               end
            end
         end
         if (last) close_line(1'b1);
      endfunction

      function int unsigned pending();
         return expected_records.size();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_record(b64rl_pkg::rsp_type got);
         b64rl_pkg::rsp_type want;
         if (expected_records.size() == 0) begin
            $display("%0t: record with none expected, expected nothing, got status %0d",
                     $time, got.status);
            errors++;
            return;
         end
         want = expected_records.pop_front();
         checked++;
         compare_field("status",      want.status,      got.status);
         compare_field("year_offset", want.year_offset, got.year_offset);
         compare_field("month",       want.month,       got.month);
         compare_field("day",         want.day,         got.day);
         compare_field("hour",        want.hour,        got.hour);
         compare_field("minute",      want.minute,      got.minute);
         compare_field("second",      want.second,      got.second);
         compare_field("power_watts", want.power_watts, got.power_watts);
         compare_field("cost_cents",  want.cost_cents,  got.cost_cents);
         compare_field("voltage_raw", want.voltage_raw, got.voltage_raw);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64rl_req_if req_if();
   b64rl_rsp_if rsp_if();

   base64_record_line_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   record_scoreboard sb = new;

   // Chance in percent that the sender or the receiver holds off in a cycle.
   int unsigned send_idle_pct = 37;
   int unsigned recv_idle_pct = 64;

   // Characters accepted by the block, dropped ones included.
   int unsigned chars_taken = 0;
   int unsigned cycle_count = 0;

   always #1 clock = ~clock;

   // Every input of the block holds a known value before the first edge.
   initial begin
      req_if.valid       = 1'b0;
      req_if.char_code   = '0;
      req_if.ends_stream = 1'b0;
      rsp_if.ready       = 1'b0;
   end

   // Result side. A record is taken at an edge where valid and ready are both
   // high; ready is then redrawn for the next cycle with one assignment.
   always @(posedge clock) begin
      b64rl_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status      = rsp_if.status;
         got.year_offset = rsp_if.year_offset;
         got.month       = rsp_if.month;
         got.day         = rsp_if.day;
         got.hour        = rsp_if.hour;
         got.minute      = rsp_if.minute;
         got.second      = rsp_if.second;
         got.power_watts = rsp_if.power_watts;
         got.cost_cents  = rsp_if.cost_cents;
         got.voltage_raw = rsp_if.voltage_raw;
         sb.check_record(got);
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d records outstanding",
                  $time, sb.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // Index 0 to 63 into the base64 alphabet.
   function automatic logic [7:0] alphabet_char(int unsigned idx);
      if (idx < b64rl_pkg::SEXTET_LOWER_BASE)
         return 8'(b64rl_pkg::CHAR_UPPER_A + idx);
      if (idx < b64rl_pkg::SEXTET_DIGIT_BASE)
         return 8'(b64rl_pkg::CHAR_LOWER_A + idx - b64rl_pkg::SEXTET_LOWER_BASE);
      if (idx < b64rl_pkg::SEXTET_PLUS)
         return 8'(b64rl_pkg::CHAR_DIGIT_0 + idx - b64rl_pkg::SEXTET_DIGIT_BASE);
      if (idx == b64rl_pkg::SEXTET_PLUS)
         return b64rl_pkg::CHAR_PLUS;
      return b64rl_pkg::CHAR_SLASH;
   endfunction

   // A legal payload character, now and then the pad character.
   function automatic logic [7:0] random_b64();
      if ($urandom_range(19) == 0) return b64rl_pkg::CHAR_PAD;
      return alphabet_char($urandom_range(63));
   endfunction

   // A byte that is neither in the alphabet, nor the pad character, nor a newline.
   function automatic logic [7:0] random_invalid();
      logic [7:0] c;
      logic [5:0] v;
      c = 8'($urandom_range(255));
      while (record_scoreboard::decode_sextet(c, v) || c == b64rl_pkg::CHAR_NEWLINE)
         c = 8'($urandom_range(255));
      return c;
   endfunction

   // Offers one character and waits until the block takes it. Valid stays
   // high after the handshake so that items can follow back to back; it only
   // drops when the sender decides to idle or waits for the owed records.
   task automatic send_char(input logic [7:0] c, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.char_code   <= c;
      req_if.ends_stream <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_char(c, last);
      chars_taken++;
   endtask

   // Sends a text string; the final character may be marked as stream end.
   task automatic send_text(input string s, input bit last_on_final);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], last_on_final && (i == s.len() - 1));
   endtask

   task automatic send_payload(input int unsigned n);
      repeat (n) send_char(random_b64(), 1'b0);
   endtask

   // The sender stops and waits until every owed record has been taken.
   task automatic wait_for_records();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One line of a stream. Most lines are complete records with random
   // content; the rest are short, long, cut-off, corrupted or pure noise.
   task automatic send_random_line();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         send_payload(4 * 6);
         send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      end else if (kind < 70) begin
         send_payload(4 * $urandom_range(0, 5));
         send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      end else if (kind < 78) begin
         send_payload(4 * $urandom_range(7, 9));
         send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      end else if (kind < 86) begin
         send_payload(4 * $urandom_range(0, 6) + $urandom_range(1, 3));
         send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      end else if (kind < 94) begin
         // A bad character mid-line; whatever follows is dropped.
         send_payload($urandom_range(0, 30));
         send_char(random_invalid(), 1'b0);
         repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(255)), 1'b0);
      end else begin
         repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // A stream is a few lines and then one character marked as the end,
   // which also releases the block from an error.
   task automatic send_random_stream();
      int unsigned pick;
      repeat ($urandom_range(1, 4)) send_random_line();
      pick = $urandom_range(9);
      if (pick < 5)
         send_char(b64rl_pkg::CHAR_NEWLINE, 1'b1);
      else if (pick < 8)
         send_char(random_b64(), 1'b1);
      else
         send_char(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned goal;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      goal = chars_taken + PHASE_ITEMS;
      while (chars_taken < goal) begin
         send_random_stream();
         if ($urandom_range(9) == 0) wait_for_records();
      end
      wait_for_records();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty line gives a short record of zeros.
      send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      // Both ends of every alphabet range, closed early: a short record.
      send_text("AZaz09+/", 1'b0);
      send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      // Two sextets left at the newline: error, then everything is dropped
      // until a character that ends the stream.
      send_text("AB", 1'b0);
      send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      send_text("x", 1'b0);
      send_char(b64rl_pkg::CHAR_NEWLINE, 1'b0);
      send_text("Q", 1'b1);
      // The lowest byte is invalid and aborts; the highest is dropped but
      // ends the stream.
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      // An invalid character that ends the stream reports without aborting.
      send_char(8'hFF, 1'b1);
      // Leftover sextets at the end of the stream.
      send_text("Az", 1'b1);
      // A group completed by the final character closes the record.
      send_text("=///", 1'b1);
      wait_for_records();

      // Random part in three idling patterns.
      run_phase(37, 64);
      run_phase(64, 37);
      run_phase(0, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected records never arrived, expected none left, got %0d",
                  $time, sb.pending(), sb.pending());
         sb.errors++;
      end

      $display("Sent %0d characters and checked %0d records over three idling patterns,",
               chars_taken, sb.checked);
      $display("including short, long, cut-off, corrupted and noisy lines and stream ends.");
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### base64_record_line_decoder.f
+incdir+hw/rtl
hw/rtl/b64rl_pkg.sv
hw/rtl/b64rl_req_if.sv
hw/rtl/b64rl_rsp_if.sv
hw/rtl/base64_record_line_decoder.sv
tb/base64_record_line_decoder_tb.sv
